FILE: rtl/printable_string_extractor_core_assert.svh
// Assertion macros for the checker file of the extractor.
`ifndef PRINTABLE_STRING_EXTRACTOR_CORE_ASSERT_SVH
`define PRINTABLE_STRING_EXTRACTOR_CORE_ASSERT_SVH

// Clocked check that is switched off while reset is high.
`define PSE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked check that also holds while reset is high.
`define PSE_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/pse_pkg.sv
`default_nettype none

package pse_pkg;

   // Field widths of the channels.
   localparam int OP_W       = 3;
   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 64;
   localparam int KIND_W     = 2;
   localparam int LEN_W      = 12;
   localparam int MIN_W      = 7;
   localparam int MAXLEN_W   = 12;
   localparam int LIMIT_W    = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // Sizing of the run buffer and the run length counter.
   localparam int MAX_PENDING = 64;
   localparam int PEND_AW     = $clog2(MAX_PENDING);
   localparam int LEN_BITS    = 12;
   localparam int LEN_MAX     = (1 << LEN_BITS) - 1;
   localparam int CMP_W       = 17;

   // Register reset values.
   localparam logic [MIN_W-1:0]    MIN_LEN_RESET   = MIN_W'(6);
   localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET   = MAXLEN_W'(512);
   localparam logic [LIMIT_W-1:0]  HIT_LIMIT_RESET = '0;
   localparam logic [LIMIT_W-1:0]  COUNT_MAX       = '1;

   // Character class bounds.
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'h7F;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;

   // Input opcodes.
   localparam logic [OP_W-1:0] OP_DATA         = 3'd0;
   localparam logic [OP_W-1:0] OP_GAP          = 3'd1;
   localparam logic [OP_W-1:0] OP_REGION_END   = 3'd2;
   localparam logic [OP_W-1:0] OP_REGION_START = 3'd3;
   localparam logic [OP_W-1:0] OP_NEW_SCAN     = 3'd4;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_HIT     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DISCARD = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_LIMIT = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic emit_drain;
   } pse_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_free;
      logic drain_needed;
      logic last_drain;
   } pse_status_type;

   // Printable ASCII or horizontal tab.
   function automatic logic text_char_check(input logic [BYTE_W-1:0] b);
      return ((b >= CHAR_SPACE) && (b < CHAR_DEL)) || (b == CHAR_TAB);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pse_req_if.sv
`default_nettype none

interface pse_req_if;
   import pse_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [BYTE_W-1:0] data_byte;
   logic [ADDR_W-1:0] byte_addr;

   modport source (output valid, opcode, data_byte, byte_addr, input ready);
   modport sink (input valid, opcode, data_byte, byte_addr, output ready);
endinterface

`default_nettype wire

FILE: rtl/pse_rsp_if.sv
`default_nettype none

interface pse_rsp_if;
   import pse_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] text_byte;
   logic [ADDR_W-1:0] hit_addr;
   logic [ADDR_W-1:0] region_base;
   logic [LEN_W-1:0]  hit_length;
   logic              limit_reached;
   logic              last;

   modport source (output valid, kind, text_byte, hit_addr, region_base, hit_length,
                   limit_reached, last, input ready);
   modport sink (input valid, kind, text_byte, hit_addr, region_base, hit_length,
                 limit_reached, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/pse_csr_if.sv
`default_nettype none

interface pse_csr_if;
   import pse_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/pse_ram.sv
`default_nettype none

module pse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/pse_ctrl.sv
`default_nettype none

module pse_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pse_pkg::pse_status_type status,
   output pse_pkg::pse_cmd_type    cmd
);
   import pse_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Words are taken only in idle and only when the output slot can take a result.
   assign req_ready      = (state_ff == S_IDLE) && status.slot_free;
   assign cmd.accept     = req_ready && req_valid;
   assign cmd.emit_drain = (state_ff == S_EMIT) && status.slot_free;

   // A qualifying word starts a drain of the buffered run, one byte per read and emit pair.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept && status.drain_needed) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (cmd.emit_drain) begin
               state_in = status.last_drain ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/pse_dp.sv
`default_nettype none

module pse_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  pse_pkg::pse_cmd_type             cmd,
   output pse_pkg::pse_status_type          status,
   input  logic [pse_pkg::OP_W-1:0]         req_opcode,
   input  logic [pse_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic [pse_pkg::ADDR_W-1:0]       req_byte_addr,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pse_pkg::KIND_W-1:0]       rsp_kind,
   output logic [pse_pkg::BYTE_W-1:0]       rsp_text_byte,
   output logic [pse_pkg::ADDR_W-1:0]       rsp_hit_addr,
   output logic [pse_pkg::ADDR_W-1:0]       rsp_region_base,
   output logic [pse_pkg::LEN_W-1:0]        rsp_hit_length,
   output logic                             rsp_limit_reached,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pse_pkg::CSR_IDX_W-1:0]    csr_reg_index,
   input  logic [pse_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pse_pkg::*;

   // Configuration registers.
   logic [MIN_W-1:0]    min_len_ff;
   logic [MAXLEN_W-1:0] max_len_ff;
   logic [LIMIT_W-1:0]  hit_limit_ff;

   // Scan state.
   logic [LEN_BITS-1:0] run_len_ff, run_len_in;
   logic [ADDR_W-1:0]   run_start_ff, run_start_in;
   logic [LIMIT_W-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [ADDR_W-1:0]   region_ff, region_in;
   logic                flag_ff, flag_in;
   logic [PEND_AW-1:0]  drain_idx_ff;

   // Output slot.
   logic                rsp_valid_ff;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0]   rsp_text_ff, rsp_text_in;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [ADDR_W-1:0]   rsp_region_ff;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic                rsp_limit_ff, rsp_limit_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_load;

   // Word decode results.
   logic                res_load;
   logic [KIND_W-1:0]   res_kind;
   logic [LEN_W-1:0]    res_len;
   logic                ram_we;
   logic [PEND_AW-1:0]  ram_waddr;
   logic                drain_cand;
   logic [BYTE_W-1:0]   ram_rdata;

   // Effective length bounds.
   logic [MIN_W-1:0]    eff_min;
   logic [CMP_W-1:0]    min_x, max_x, run_x;
   logic                qual;
   logic [LIMIT_W-1:0]  cnt_inc;
   logic                lim_after_hit;
   logic                lim_now;

   // Clamp the minimum into one to the buffer depth, and the maximum into min to LEN_MAX.
   always_comb begin
      if (min_len_ff == '0) begin
         eff_min = MIN_W'(1);
      end else if (min_len_ff > MIN_W'(MAX_PENDING)) begin
         eff_min = MIN_W'(MAX_PENDING);
      end else begin
         eff_min = min_len_ff;
      end
      min_x = CMP_W'(eff_min);
      max_x = CMP_W'(max_len_ff);
      if (max_x < min_x) begin
         max_x = min_x;
      end
      if (max_x > CMP_W'(LEN_MAX)) begin
         max_x = CMP_W'(LEN_MAX);
      end
      run_x = CMP_W'(run_len_ff);
   end

   // Hit completion and limit checks shared by all ending paths.
   assign qual          = (run_len_ff != '0) && (run_x >= min_x);
   assign cnt_inc       = (hit_cnt_ff == COUNT_MAX) ? hit_cnt_ff : hit_cnt_ff + LIMIT_W'(1);
   assign lim_after_hit = (hit_limit_ff != '0) && (cnt_inc >= hit_limit_ff);
   assign lim_now       = (hit_limit_ff != '0) && (hit_cnt_ff >= hit_limit_ff);

   // Next state and direct result for the word on the input channel.
   always_comb begin
      run_len_in   = run_len_ff;
      run_start_in = run_start_ff;
      hit_cnt_in   = hit_cnt_ff;
      region_in    = region_ff;
      flag_in      = flag_ff;
      res_load     = 1'b0;
      res_kind     = KIND_TEXT;
      res_len      = '0;
      ram_we       = 1'b0;
      ram_waddr    = run_len_ff[PEND_AW-1:0];
      drain_cand   = 1'b0;
      unique case (req_opcode)
         OP_DATA: begin
            if (!text_char_check(req_data_byte)) begin
               if (qual) begin
                  res_load   = 1'b1;
                  res_kind   = KIND_HIT;
                  res_len    = LEN_W'(run_len_ff);
                  hit_cnt_in = cnt_inc;
                  flag_in    = flag_ff || lim_after_hit;
               end
               run_len_in = '0;
            end else if (run_len_ff == '0) begin
               flag_in = flag_ff || lim_now;
               if (!(flag_ff || lim_now)) begin
                  run_start_in = req_byte_addr;
                  ram_we       = 1'b1;
                  ram_waddr    = '0;
                  run_len_in   = LEN_BITS'(1);
                  drain_cand   = (min_x == CMP_W'(1));
               end
            end else if (run_x >= max_x) begin
               if (run_x < CMP_W'(LEN_MAX)) begin
                  run_len_in = run_len_ff + LEN_BITS'(1);
               end
            end else if (run_x >= min_x) begin
               run_len_in = run_len_ff + LEN_BITS'(1);
               res_load   = 1'b1;
            end else begin
               ram_we     = 1'b1;
               run_len_in = run_len_ff + LEN_BITS'(1);
               drain_cand = ((run_x + CMP_W'(1)) == min_x);
            end
         end
         OP_GAP: begin
            if (qual) begin
               res_load = 1'b1;
               res_kind = KIND_DISCARD;
               res_len  = LEN_W'(run_len_ff);
            end
            run_len_in = '0;
         end
         OP_REGION_END, OP_REGION_START: begin
            if (qual) begin
               res_load   = 1'b1;
               res_kind   = KIND_HIT;
               res_len    = LEN_W'(run_len_ff);
               hit_cnt_in = cnt_inc;
               flag_in    = flag_ff || lim_after_hit;
            end
            run_len_in = '0;
            if (req_opcode == OP_REGION_START) begin
               region_in = req_byte_addr;
            end
         end
         OP_NEW_SCAN: begin
            run_len_in = '0;
            hit_cnt_in = '0;
            flag_in    = 1'b0;
            region_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // Run buffer holding bytes of a run that has not yet qualified.
   pse_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_PENDING)
   ) u_pend_ram (
      .clock (clock),
      .we    (ram_we && cmd.accept),
      .waddr (ram_waddr),
      .wdata (req_data_byte),
      .raddr (drain_idx_ff),
      .rdata (ram_rdata)
   );

   // Status toward the controller.
   assign status.slot_free    = !rsp_valid_ff || rsp_ready;
   assign status.drain_needed = drain_cand;
   assign status.last_drain   = (MIN_W'(drain_idx_ff) == (eff_min - MIN_W'(1)));

   // Output slot loads a direct result on accept, or a drained byte.
   assign rsp_load = (cmd.accept && res_load) || cmd.emit_drain;

   always_comb begin
      if (cmd.emit_drain) begin
         rsp_kind_in  = KIND_TEXT;
         rsp_text_in  = ram_rdata;
         rsp_len_in   = '0;
         rsp_limit_in = flag_ff;
         rsp_last_in  = status.last_drain;
      end else begin
         rsp_kind_in  = res_kind;
         rsp_text_in  = (res_kind == KIND_TEXT) ? req_data_byte : '0;
         rsp_len_in   = res_len;
         rsp_limit_in = flag_in;
         rsp_last_in  = 1'b1;
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff   <= MIN_LEN_RESET;
         max_len_ff   <= MAX_LEN_RESET;
         hit_limit_ff <= HIT_LIMIT_RESET;
         run_len_ff   <= '0;
         run_start_ff <= '0;
         hit_cnt_ff   <= '0;
         region_ff    <= '0;
         flag_ff      <= 1'b0;
         drain_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_reg_index)
               CSR_MIN_LEN:   min_len_ff   <= csr_wdata[MIN_W-1:0];
               CSR_MAX_LEN:   max_len_ff   <= csr_wdata[MAXLEN_W-1:0];
               CSR_HIT_LIMIT: hit_limit_ff <= csr_wdata[LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.accept) begin
            run_len_ff   <= run_len_in;
            run_start_ff <= run_start_in;
            hit_cnt_ff   <= hit_cnt_in;
            region_ff    <= region_in;
            flag_ff      <= flag_in;
            drain_idx_ff <= '0;
         end else if (cmd.emit_drain) begin
            drain_idx_ff <= drain_idx_ff + PEND_AW'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload; the hit address shows the run start after the word, the region base the register at load.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_text_ff   <= rsp_text_in;
         rsp_addr_ff   <= cmd.emit_drain ? run_start_ff : run_start_in;
         rsp_region_ff <= region_ff;
         rsp_len_ff    <= rsp_len_in;
         rsp_limit_ff  <= rsp_limit_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_text_byte     = rsp_text_ff;
   assign rsp_hit_addr      = rsp_addr_ff;
   assign rsp_region_base   = rsp_region_ff;
   assign rsp_hit_length    = rsp_len_ff;
   assign rsp_limit_reached = rsp_limit_ff;
   assign rsp_last          = rsp_last_ff;
   assign csr_ready         = 1'b1;

endmodule

`default_nettype wire

FILE: rtl/printable_string_extractor_core.sv
// Printable string extractor.
// req_ch carries one word per valid/ready handshake: an opcode (data byte, unreadable
// gap, region end, region start, new scan), the byte and its address. rsp_ch returns
// result words: text bytes of a qualified run, hit-complete and hit-discarded markers;
// the last word caused by an input word has last set. csr_ch writes min_len, max_len
// and hit_limit by index and is always ready; write it only while the block is idle.
// A result appears in the cycle after its input word is taken, from a single output
// register. A word that causes at most one result does not hold the input, so data bytes
// flow at one per cycle while the receiver keeps up. A byte that lets a run reach min_len
// drains the buffered run from the run buffer RAM, each byte by a registered read then
// an emit, before the next word is taken.
// Reset clears the run, the hit count, the limit flag and the region base and loads
// the register defaults (6, 512, 0). When the receiver stalls, the result word holds
// and the input channel deasserts ready until the output register is free again.
`default_nettype none

module printable_string_extractor_core (
   input logic        clock,
   input logic        reset,
   pse_req_if.sink    req_ch,
   pse_rsp_if.source  rsp_ch,
   pse_csr_if.sink    csr_ch
);
   import pse_pkg::*;

   pse_cmd_type    cmd;
   pse_status_type status;

   // Sequencer for accepting words and draining buffered runs.
   pse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Scan state, run buffer and output register.
   pse_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_ch.opcode),
      .req_data_byte     (req_ch.data_byte),
      .req_byte_addr     (req_ch.byte_addr),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_kind          (rsp_ch.kind),
      .rsp_text_byte     (rsp_ch.text_byte),
      .rsp_hit_addr      (rsp_ch.hit_addr),
      .rsp_region_base   (rsp_ch.region_base),
      .rsp_hit_length    (rsp_ch.hit_length),
      .rsp_limit_reached (rsp_ch.limit_reached),
      .rsp_last          (rsp_ch.last),
      .csr_valid         (csr_ch.valid),
      .csr_ready         (csr_ch.ready),
      .csr_reg_index     (csr_ch.reg_index),
      .csr_wdata         (csr_ch.wdata)
   );

endmodule

`default_nettype wire

FILE: rtl/pse_checker.sv
`default_nettype none
`include "printable_string_extractor_core_assert.svh"

module pse_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [pse_pkg::KIND_W-1:0]   rsp_kind,
   input logic [pse_pkg::BYTE_W-1:0]   rsp_text_byte,
   input logic [pse_pkg::ADDR_W-1:0]   rsp_hit_addr,
   input logic [pse_pkg::LEN_W-1:0]    rsp_hit_length,
   input logic                         rsp_last
);
   import pse_pkg::*;

   // The output register is empty in the cycle after reset.
   `PSE_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // A stalled result word holds.
   `PSE_ASSERT(a_stall_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_text_byte) && $stable(rsp_hit_addr) && $stable(rsp_last), "stalled result changed")

   // Text bytes carry no length.
   `PSE_ASSERT(a_text_len, rsp_valid && rsp_kind == KIND_TEXT |-> rsp_hit_length == '0, "text byte with length")

   // A marker is always the final result of its input word.
   `PSE_ASSERT(a_marker_last, rsp_valid && rsp_kind != KIND_TEXT |-> rsp_last, "marker without last")

endmodule

bind printable_string_extractor_core pse_checker u_pse_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_kind       (rsp_ch.kind),
   .rsp_text_byte  (rsp_ch.text_byte),
   .rsp_hit_addr   (rsp_ch.hit_addr),
   .rsp_hit_length (rsp_ch.hit_length),
   .rsp_last       (rsp_ch.last)
);

`default_nettype wire
